// File: sv/lssg_pkg.sv
// lssg_pkg: shared types, constants and small lookup functions of the log sine sweep generator
// no dependencies; imported by lssg_mul, lssg_cfg and log_sine_sweep_generator
package lssg_pkg;

  // shared multiplier operand and product widths
  localparam int MUL_W  = 33;
  localparam int PROD_W = 2 * MUL_W;

  // configuration port
  localparam int CFG_IDX_W  = 3;
  localparam int CFG_DATA_W = 40;

  localparam logic [CFG_IDX_W-1:0] CFG_LF_FIRST     = 3'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_LF_LAST      = 3'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_SWEEP_STEP   = 3'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_TURNS_PER_HZ = 3'd3;
  localparam logic [CFG_IDX_W-1:0] CFG_AMPLITUDE    = 3'd4;

  // reset values of the registers
  localparam logic [31:0] RST_LF_FIRST     = 32'd349242581;
  localparam logic [31:0] RST_LF_LAST      = 32'd1154548949;
  localparam logic [23:0] RST_SWEEP_STEP   = 24'd3652;
  localparam logic [39:0] RST_TURNS_PER_HZ = 40'd6382652533;
  localparam logic [15:0] RST_AMPLITUDE    = 16'd16384;

  // fixed-point constants
  localparam logic [MUL_W-1:0] LOG2_10_Q30 = 33'd3566893132;
  localparam logic [MUL_W-1:0] LN2_Q32     = 33'd2977044472;
  localparam logic [MUL_W-1:0] HALF_PI_Q30 = 33'd1686629713;
  localparam logic [MUL_W-1:0] ONE_Q32     = 33'h1_0000_0000;

  // series lengths
  localparam int EXP_TERMS = 12;
  localparam int SIN_TERMS = 6;

  // output field width
  localparam int OUT_W = 16;

  typedef struct packed {
    logic [31:0] lf_first;
    logic [31:0] lf_last;
    logic [23:0] sweep_step;
    logic [39:0] turns_per_hz;
    logic [15:0] amplitude;
  } cfg_t;

  // floor(2^32 / d) for every divisor the series use
  function automatic logic [MUL_W-1:0] div_recip(input logic [7:0] d);
    logic [MUL_W-1:0] r;
    case (d)
      8'd1:    r = 33'd4294967296;
      8'd2:    r = 33'd2147483648;
      8'd3:    r = 33'd1431655765;
      8'd4:    r = 33'd1073741824;
      8'd5:    r = 33'd858993459;
      8'd6:    r = 33'd715827882;
      8'd7:    r = 33'd613566756;
      8'd8:    r = 33'd536870912;
      8'd9:    r = 33'd477218588;
      8'd10:   r = 33'd429496729;
      8'd11:   r = 33'd390451572;
      8'd12:   r = 33'd357913941;
      8'd20:   r = 33'd214748364;
      8'd42:   r = 33'd102261126;
      8'd72:   r = 33'd59652323;
      8'd110:  r = 33'd39045157;
      8'd156:  r = 33'd27531841;
      default: r = '0;
    endcase
    return r;
  endfunction

  // (2k)(2k+1) divisor of the k-th sine term
  function automatic logic [7:0] sin_div(input logic [3:0] k);
    logic [7:0] d;
    case (k)
      4'd1:    d = 8'd6;
      4'd2:    d = 8'd20;
      4'd3:    d = 8'd42;
      4'd4:    d = 8'd72;
      4'd5:    d = 8'd110;
      4'd6:    d = 8'd156;
      default: d = 8'd1;
    endcase
    return d;
  endfunction

endpackage

// File: sv/lssg_mul.sv
// lssg_mul: shared unsigned multiplier with registered product
// depends on lssg_pkg for the operand width
module lssg_mul
  import lssg_pkg::*;
(
  input  logic              clk,
  input  logic [MUL_W-1:0]  op_a,
  input  logic [MUL_W-1:0]  op_b,
  output logic [PROD_W-1:0] prod_r
);

  always_ff @(posedge clk) begin
    prod_r <= PROD_W'(op_a) * PROD_W'(op_b);
  end

endmodule

// File: sv/lssg_cfg.sv
// lssg_cfg: configuration register file, index decode and width masking
// depends on lssg_pkg for cfg_t, index codes and reset values
module lssg_cfg
  import lssg_pkg::*;
(
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  cfg_valid,
  output logic                  cfg_ready,
  input  logic [CFG_IDX_W-1:0]  cfg_index,
  input  logic [CFG_DATA_W-1:0] cfg_data,
  output cfg_t                  cfg_r
);

  // writes must land with generator idle; unenforced, always ready
  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.lf_first     <= RST_LF_FIRST;
      cfg_r.lf_last      <= RST_LF_LAST;
      cfg_r.sweep_step   <= RST_SWEEP_STEP;
      cfg_r.turns_per_hz <= RST_TURNS_PER_HZ;
      cfg_r.amplitude    <= RST_AMPLITUDE;
    end else if (cfg_valid && cfg_ready) begin
      unique case (cfg_index)
        CFG_LF_FIRST:     cfg_r.lf_first     <= cfg_data[31:0];
        CFG_LF_LAST:      cfg_r.lf_last      <= cfg_data[31:0];
        CFG_SWEEP_STEP:   cfg_r.sweep_step   <= cfg_data[23:0];
        CFG_TURNS_PER_HZ: cfg_r.turns_per_hz <= cfg_data[39:0];
        CFG_AMPLITUDE:    cfg_r.amplitude    <= cfg_data[15:0];
        default: ;
      endcase
    end
  end

endmodule

// File: sv/log_sine_sweep_generator.sv
// log_sine_sweep_generator: top level, sequencer and datapath around one shared multiplier
// depends on lssg_pkg, lssg_mul and lssg_cfg
//
// usage
//   input channel (in_valid / in_stall / in_restart): one transfer per audio frame;
//   in_restart set zeroes the phase and reloads the start log frequency first.
//   result channel (out_valid / out_stall): one stereo sample pair per frame plus
//   out_sweep_wrapped, set when the log frequency reloaded after that frame.
//   config channel (cfg_valid / cfg_ready / cfg_index / cfg_data): always ready,
//   written between frames; a new start value reaches the sweep on restart or wrap.
// timing
//   a frame runs from its input transfer until the sequencer is idle again; the result
//   shows on out_valid in the same cycle that a new input transfer becomes possible.
//   frame length is set by the single 33x33 multiplier: 12 exponential terms and 6 sine
//   terms, plus setup, the phase increment and output scaling, all run on it in turn.
//   in_stall is high while a frame is in work.  a finished result waits in the output
//   register while out_stall is high and the next frame may already be accepted; that
//   frame holds in its last step until the register frees up.
// reset
//   synchronous rst_n restores register defaults, zero phase and the start frequency.
module log_sine_sweep_generator
  import lssg_pkg::*;
#(
  parameter int PHASE_BITS       = 32,
  parameter int SINE_TABLE_DEPTH = 256,
  parameter int SAMPLE_BITS      = 16
) (
  input  logic                   clk,
  input  logic                   rst_n,
  // input channel
  input  logic                   in_valid,
  output logic                   in_stall,
  input  logic                   in_restart,
  // result channel
  output logic                   out_valid,
  input  logic                   out_stall,
  output logic signed [OUT_W-1:0] out_left_sample,
  output logic signed [OUT_W-1:0] out_right_sample,
  output logic                   out_sweep_wrapped,
  // configuration channel
  input  logic                   cfg_valid,
  output logic                   cfg_ready,
  input  logic [CFG_IDX_W-1:0]   cfg_index,
  input  logic [CFG_DATA_W-1:0]  cfg_data
);

  // sine index bits (depth is a power of two)
  localparam int TBL_W = $clog2(SINE_TABLE_DEPTH);
  // rounding shift of the scaled sine
  localparam int RND_SH = 46 - SAMPLE_BITS;
  localparam int EXT_W  = (SAMPLE_BITS > OUT_W) ? SAMPLE_BITS : OUT_W;
  localparam logic [47:0] POS_LIM  = 48'((64'd1 << (SAMPLE_BITS - 1)) - 64'd1);
  localparam logic [47:0] NEG_LIM  = 48'(64'd1 << (SAMPLE_BITS - 1));
  localparam logic [47:0] RND_HALF = 48'(64'd1 << (RND_SH - 1));

  typedef enum logic [4:0] {
    S_IDLE, S_LOGMUL, S_LNMUL, S_TLOAD,
    S_EMUL, S_ERCP, S_ECHK, S_EFIX,
    S_FMUL0, S_FMUL1, S_FSUM, S_FSHIFT,
    S_AMUL, S_ALOAD,
    S_TMUL1, S_TMUL2, S_TRCP, S_TCHK, S_TFIX,
    S_OMUL, S_OUT
  } state_t;

  state_t state_r;

  cfg_t cfg;

  logic [MUL_W-1:0]  op_a;
  logic [MUL_W-1:0]  op_b;
  logic [PROD_W-1:0] prod_r;

  // sweep state
  logic [PHASE_BITS-1:0] phase_r;
  logic [31:0]           log_freq_r;

  // series working registers
  logic [5:0]             n_r;       // integer part of log2 of the frequency
  logic [31:0]            t_r;       // series variable (t or sine angle)
  logic [MUL_W-1:0]       term_r;
  logic [MUL_W-1:0]       acc_r;     // 2^f, Q1.32
  logic [31:0]            x_r;       // dividend of the current term
  logic [MUL_W-1:0]       q0_r;      // estimated quotient
  logic [3:0]             k_r;
  logic signed [33:0]     s_r;       // sine, signed Q4.30
  logic [1:0]             quad_r;
  logic [64:0]            plo_r;
  logic [72:0]            pfull_r;   // 2^f times turns_per_hz
  logic [PHASE_BITS-1:0]  inc_r;

  // output register
  logic                   out_valid_r;
  logic signed [OUT_W-1:0] out_sample_r;
  logic                   out_wrapped_r;

  logic in_fire;
  logic out_free;

  // sine angle from the phase
  logic [TBL_W-1:0] idx;
  logic [29:0]      r30;
  logic [30:0]      rm;

  // term quotient correction
  logic [MUL_W-1:0] q_fix;

  // phase increment window
  logic [135:0] wide;

  // sample scaling
  logic [MUL_W-1:0]             mag_s;
  logic [47:0]                  rnd;
  logic [SAMPLE_BITS-1:0]       mag_c;
  logic signed [SAMPLE_BITS-1:0] smp_s;
  logic signed [EXT_W-1:0]      smp_ext;

  // sweep advance
  logic [32:0] lf_sum;
  logic        wrap;

  lssg_cfg u_cfg (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .cfg_r     (cfg)
  );

  lssg_mul u_mul (
    .clk    (clk),
    .op_a   (op_a),
    .op_b   (op_b),
    .prod_r (prod_r)
  );

  assign in_stall  = (state_r != S_IDLE);
  assign in_fire   = in_valid && !in_stall;
  assign out_free  = !out_valid_r || !out_stall;

  assign out_valid         = out_valid_r;
  assign out_left_sample   = out_sample_r;
  assign out_right_sample  = out_sample_r;
  assign out_sweep_wrapped = out_wrapped_r;

  // quadrant and mirrored remainder of the table point
  assign idx = phase_r[PHASE_BITS-1 -: TBL_W];
  assign r30 = {idx[TBL_W-3:0], {(32 - TBL_W){1'b0}}};
  assign rm  = idx[TBL_W-2] ? (31'h4000_0000 - {1'b0, r30}) : {1'b0, r30};

  // quotient estimate is exact or one low; the product of q0+1 and d decides
  assign q_fix = (prod_r <= PROD_W'(x_r)) ? (q0_r + MUL_W'(1)) : q0_r;

  // increment = 2^f * turns_per_hz * 2^n / 2^48, wrapped to the phase width
  assign wide = {63'b0, pfull_r} << n_r;

  // negative series sum clamps to zero
  assign mag_s = s_r[33] ? '0 : s_r[MUL_W-1:0];

  // round half up, then saturate per sign
  always_comb begin
    rnd = (prod_r[47:0] + RND_HALF) >> RND_SH;
    if (quad_r[1]) begin
      mag_c = (rnd > NEG_LIM) ? NEG_LIM[SAMPLE_BITS-1:0] : rnd[SAMPLE_BITS-1:0];
      smp_s = $signed(~mag_c + SAMPLE_BITS'(1));
    end else begin
      mag_c = (rnd > POS_LIM) ? POS_LIM[SAMPLE_BITS-1:0] : rnd[SAMPLE_BITS-1:0];
      smp_s = $signed(mag_c);
    end
    smp_ext = EXT_W'(smp_s);
  end

  assign lf_sum = {1'b0, log_freq_r} + 33'(cfg.sweep_step);
  assign wrap   = (lf_sum >= {1'b0, cfg.lf_last});

  // operand select of the shared multiplier
  always_comb begin
    op_a = '0;
    op_b = '0;
    unique case (state_r) inside
      S_LOGMUL: begin
        op_a = MUL_W'(log_freq_r);
        op_b = LOG2_10_Q30;
      end
      S_LNMUL: begin
        op_a = MUL_W'(prod_r[57:26]);
        op_b = LN2_Q32;
      end
      S_EMUL: begin
        op_a = term_r;
        op_b = MUL_W'(t_r);
      end
      S_ERCP: begin
        op_a = MUL_W'(prod_r[63:32]);
        op_b = div_recip(8'(k_r));
      end
      S_ECHK: begin
        op_a = MUL_W'(prod_r[63:32]) + MUL_W'(1);
        op_b = MUL_W'(k_r);
      end
      S_FMUL0: begin
        op_a = acc_r;
        op_b = MUL_W'(cfg.turns_per_hz[31:0]);
      end
      S_FMUL1: begin
        op_a = acc_r;
        op_b = MUL_W'(cfg.turns_per_hz[39:32]);
      end
      S_AMUL: begin
        op_a = MUL_W'(rm);
        op_b = HALF_PI_Q30;
      end
      S_TMUL1: begin
        op_a = term_r;
        op_b = MUL_W'(t_r);
      end
      S_TMUL2: begin
        op_a = MUL_W'(prod_r[61:30]);
        op_b = MUL_W'(t_r);
      end
      S_TRCP: begin
        op_a = MUL_W'(prod_r[61:30]);
        op_b = div_recip(sin_div(k_r));
      end
      S_TCHK: begin
        op_a = MUL_W'(prod_r[63:32]) + MUL_W'(1);
        op_b = MUL_W'(sin_div(k_r));
      end
      // held through S_OUT so the scaled product stays put while the output waits
      S_OMUL, S_OUT: begin
        op_a = mag_s;
        op_b = MUL_W'(cfg.amplitude);
      end
      default: ;
    endcase
  end

  // sequencer and registered outputs
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      out_valid_r <= 1'b0;
      phase_r     <= '0;
      log_freq_r  <= RST_LF_FIRST;
    end else begin
      // a transfer empties the output register unless the final step refills it
      if (out_valid_r && !out_stall && state_r != S_OUT) begin
        out_valid_r <= 1'b0;
      end
      unique case (state_r)
        S_IDLE: begin
          if (in_fire) begin
            if (in_restart) begin
              phase_r    <= '0;
              log_freq_r <= cfg.lf_first;
            end
            state_r <= S_LOGMUL;
          end
        end
        S_LOGMUL: state_r <= S_LNMUL;
        S_LNMUL: begin
          n_r     <= prod_r[63:58];
          state_r <= S_TLOAD;
        end
        S_TLOAD: begin
          t_r     <= prod_r[63:32];
          term_r  <= ONE_Q32;
          acc_r   <= ONE_Q32;
          k_r     <= 4'd1;
          state_r <= S_EMUL;
        end
        // exponential series: term = (term * t >> 32) / k
        S_EMUL: state_r <= S_ERCP;
        S_ERCP: begin
          x_r     <= prod_r[63:32];
          state_r <= S_ECHK;
        end
        S_ECHK: begin
          q0_r    <= MUL_W'(prod_r[63:32]);
          state_r <= S_EFIX;
        end
        S_EFIX: begin
          term_r <= q_fix;
          acc_r  <= acc_r + q_fix;
          if (k_r == 4'(EXP_TERMS)) begin
            state_r <= S_FMUL0;
          end else begin
            k_r     <= k_r + 4'd1;
            state_r <= S_EMUL;
          end
        end
        // 33 x 40 product in two partials
        S_FMUL0: state_r <= S_FMUL1;
        S_FMUL1: begin
          plo_r   <= prod_r[64:0];
          state_r <= S_FSUM;
        end
        S_FSUM: begin
          pfull_r <= 73'(plo_r) + {prod_r[40:0], 32'b0};
          state_r <= S_FSHIFT;
        end
        S_FSHIFT: begin
          inc_r   <= wide[48 +: PHASE_BITS];
          state_r <= S_AMUL;
        end
        S_AMUL: begin
          quad_r  <= idx[TBL_W-1 -: 2];
          state_r <= S_ALOAD;
        end
        S_ALOAD: begin
          t_r     <= prod_r[61:30];
          term_r  <= MUL_W'(prod_r[61:30]);
          s_r     <= $signed({2'b00, prod_r[61:30]});
          k_r     <= 4'd1;
          state_r <= S_TMUL1;
        end
        // sine series: term = ((term * a >> 30) * a >> 30) / (2k(2k+1))
        S_TMUL1: state_r <= S_TMUL2;
        S_TMUL2: state_r <= S_TRCP;
        S_TRCP: begin
          x_r     <= prod_r[61:30];
          state_r <= S_TCHK;
        end
        S_TCHK: begin
          q0_r    <= MUL_W'(prod_r[63:32]);
          state_r <= S_TFIX;
        end
        S_TFIX: begin
          term_r <= q_fix;
          if (k_r[0]) begin
            s_r <= s_r - $signed({1'b0, q_fix});
          end else begin
            s_r <= s_r + $signed({1'b0, q_fix});
          end
          if (k_r == 4'(SIN_TERMS)) begin
            state_r <= S_OMUL;
          end else begin
            k_r     <= k_r + 4'd1;
            state_r <= S_TMUL1;
          end
        end
        S_OMUL: state_r <= S_OUT;
        S_OUT: begin
          if (out_free) begin
            out_valid_r   <= 1'b1;
            out_sample_r  <= smp_ext[OUT_W-1:0];
            out_wrapped_r <= wrap;
            phase_r       <= phase_r + inc_r;
            log_freq_r    <= wrap ? cfg.lf_first : lf_sum[31:0];
            state_r       <= S_IDLE;
          end
        end
        default: state_r <= S_IDLE;
      endcase
    end
  end

  // an accepted frame always starts with the log frequency product
  a_fire_starts: assert property (@(posedge clk) disable iff (!rst_n)
    in_fire |=> state_r == S_LOGMUL)
    else $error("accepted frame did not start the sequence");

  // phase only moves on a restart transfer or at the end of a frame
  a_phase_hold: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r != S_OUT && !in_fire) |=> $stable(phase_r))
    else $error("phase changed in the middle of a frame");

  // a result appears only out of the final step
  a_result_src: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(out_valid_r) |-> $past(state_r) == S_OUT)
    else $error("result raised outside the final step");

  // a flagged frame leaves the sweep at its start value
  a_wrap_reload: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_OUT && out_free && wrap) |=>
      log_freq_r == $past(cfg.lf_first))
    else $error("wrapped sweep did not reload the start value");

  // exponential term counter stays within the series
  a_exp_count: assert property (@(posedge clk) disable iff (!rst_n)
    state_r == S_EFIX |-> (k_r >= 4'd1 && k_r <= 4'(EXP_TERMS)))
    else $error("exponential term counter out of range");

endmodule
